>>> rtl/core/ctcgd_pkg.sv
`default_nettype none
package ctcgd_pkg;

   localparam int LOGIT_W      = 16;
   localparam int CONF_W       = 16;
   localparam int CSR_W        = 7;
   localparam int TOK_W        = 7;
   localparam int TOKEN_ID_W   = 6;
   localparam int JOB_IDX_W    = 8;
   localparam int DIFF_W       = 13;
   localparam int EXP_W        = 17;
   localparam int EXP_STEPS    = 13;
   localparam logic [TOK_W-1:0]  PREV_NONE = 7'h7f;
   localparam logic [CSR_W-1:0]  VOCAB_RESET = 7'd32;
   localparam logic [EXP_W-1:0]  EXP_ONE = 17'h10000;
   localparam logic [CONF_W-1:0] CONF_SAT = 16'hffff;
   localparam logic [DIFF_W-1:0] DIFF_CLIP = 13'd4096;

   typedef struct packed {
      logic signed [LOGIT_W-1:0] logit;
      logic                      end_of_utterance;
   } req_type;

   typedef struct packed {
      logic                  kind;
      logic [TOKEN_ID_W-1:0] token_id;
      logic [CONF_W-1:0]     token_confidence;
      logic [CONF_W-1:0]     utterance_confidence;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic                      row_valid;
      logic                      eou;
      logic                      bank;
      logic signed [LOGIT_W-1:0] max_value;
      logic [JOB_IDX_W-1:0]      max_index;
      logic [JOB_IDX_W-1:0]      last_pos;
   } job_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_READ,
      B_LOAD,
      B_EXP,
      B_ACC,
      B_DIV,
      B_TOK,
      B_AVG,
      B_SUM
   } back_state_type;

   // round(65536 * exp(-2^b / 256))
   function automatic logic [15:0] exp_factor(input logic [3:0] b);
      logic [15:0] f;
      case (b)
         4'd0:    f = 16'd65280;
         4'd1:    f = 16'd65026;
         4'd2:    f = 16'd64520;
         4'd3:    f = 16'd63520;
         4'd4:    f = 16'd61565;
         4'd5:    f = 16'd57835;
         4'd6:    f = 16'd51039;
         4'd7:    f = 16'd39750;
         4'd8:    f = 16'd24109;
         4'd9:    f = 16'd8869;
         4'd10:   f = 16'd1200;
         4'd11:   f = 16'd22;
         default: f = 16'd0;
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/ctcgd_fifo.sv
`default_nettype none
module ctcgd_fifo
   import ctcgd_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   // two-entry queue
   logic [WIDTH-1:0] slot_ff [2];
   logic             wptr_ff, wptr_in;
   logic             rptr_ff, rptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wptr_in  = wptr_ff ^ do_push;
      rptr_in  = rptr_ff ^ do_pop;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/ctcgd_front.sv
`default_nettype none
module ctcgd_front
   import ctcgd_pkg::*;
#(
   parameter int VOCAB_MAX = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_enable,
   input  wire logic [CSR_W-1:0]               csr_write_data,
   input  wire logic                           req_push,
   input  wire req_type                        req_data,
   output logic                                req_full,
   output logic                                mem_wr_en,
   output logic [$clog2(VOCAB_MAX):0]          mem_wr_addr,
   output logic signed [LOGIT_W-1:0]           mem_wr_data,
   output logic                                job_push,
   output job_type                             job_data,
   input  wire logic                           job_done
);

   localparam int POS_W = $clog2(VOCAB_MAX);
   localparam int CV_W  = ($clog2(VOCAB_MAX + 1) > CSR_W) ? $clog2(VOCAB_MAX + 1) : CSR_W;
   localparam logic [CV_W-1:0] VMAX = CV_W'(VOCAB_MAX);

   logic [CSR_W-1:0]          vocab_ff;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic signed [LOGIT_W-1:0] max_ff, max_in;
   logic [POS_W-1:0]          idx_ff, idx_in;
   logic                      bank_ff, bank_in;
   logic [1:0]                busy_ff, busy_in;
   logic [CV_W-1:0]           eff_count;
   logic [CV_W-1:0]           pos_next;
   logic                      accept, row_end;

   always_comb begin
      eff_count = CV_W'(vocab_ff);
      if (vocab_ff == '0) begin
         eff_count = CV_W'(1);
      end else if (eff_count > VMAX) begin
         eff_count = VMAX;
      end
   end

   // both row banks owned by outstanding jobs
   assign req_full = (busy_ff == 2'd2);
   assign accept   = req_push && !req_full;
   assign pos_next = CV_W'(pos_ff) + CV_W'(1);
   assign row_end  = (pos_next >= eff_count);

   assign mem_wr_en   = accept;
   assign mem_wr_addr = {bank_ff, pos_ff};
   assign mem_wr_data = req_data.logit;

   always_comb begin
      max_in = max_ff;
      idx_in = idx_ff;
      if (pos_ff == '0 || req_data.logit > max_ff) begin
         max_in = req_data.logit;
         idx_in = pos_ff;
      end
   end

   assign job_push           = accept && (row_end || req_data.end_of_utterance);
   assign job_data.row_valid = row_end;
   assign job_data.eou       = req_data.end_of_utterance;
   assign job_data.bank      = bank_ff;
   assign job_data.max_value = max_in;
   assign job_data.max_index = JOB_IDX_W'(idx_in);
   assign job_data.last_pos  = JOB_IDX_W'(pos_ff);

   always_comb begin
      pos_in  = pos_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (accept) begin
         pos_in = job_push ? '0 : pos_ff + POS_W'(1);
      end
      if (job_push) begin
         bank_in = !bank_ff;
      end
      if (job_push && !job_done) begin
         busy_in = busy_ff + 2'd1;
      end else if (job_done && !job_push) begin
         busy_in = busy_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vocab_ff <= VOCAB_RESET;
         pos_ff   <= '0;
         bank_ff  <= 1'b0;
         busy_ff  <= 2'd0;
      end else begin
         if (csr_write_enable) begin
            vocab_ff <= csr_write_data;
         end
         pos_ff  <= pos_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         max_ff <= max_in;
         idx_ff <= idx_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/ctcgd_back.sv
`default_nettype none
module ctcgd_back
   import ctcgd_pkg::*;
#(
   parameter int VOCAB_MAX = 64,
   parameter int MAX_STEPS = 65536
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      mem_wr_en,
   input  wire logic [$clog2(VOCAB_MAX):0] mem_wr_addr,
   input  wire logic signed [LOGIT_W-1:0] mem_wr_data,
   input  wire logic                      job_empty,
   input  wire job_type                   job_data,
   output logic                           job_pop,
   output logic                           job_done,
   input  wire logic                      out_full,
   output logic                           out_push,
   output rsp_type                        out_data
);

   localparam int POS_W = $clog2(VOCAB_MAX);
   localparam int RS_W  = EXP_W + POS_W;
   localparam int CNT_W = $clog2(MAX_STEPS + 1);
   localparam int CS_W  = CNT_W + CONF_W;
   localparam int DV_W  = (CS_W > 33) ? CS_W : 33;
   localparam int D_W   = (RS_W > CNT_W) ? RS_W : CNT_W;
   localparam int DC_W  = $clog2(DV_W + 1);
   localparam logic [CNT_W-1:0] STEP_CAP = CNT_W'(MAX_STEPS);
   localparam logic [DV_W-1:0]  DIV_ONE  = DV_W'(64'h1_0000_0000);

   logic signed [LOGIT_W-1:0] mem [2**(POS_W+1)];

   back_state_type            state_ff, state_in;
   job_type                   job_ff;
   logic [POS_W-1:0]          i_ff;
   logic signed [LOGIT_W-1:0] rdata_ff;
   logic [DIFF_W-1:0]         diff_ff;
   logic [EXP_W-1:0]          e_ff;
   logic [3:0]                bit_ff;
   logic [RS_W-1:0]           rowsum_ff;
   logic [D_W-1:0]            rem_ff;
   logic [DV_W-1:0]           dvd_ff;
   logic [D_W-1:0]            dvs_ff;
   logic [EXP_W-1:0]          quo_ff;
   logic [DC_W-1:0]           dcnt_ff;
   logic                      div_avg_ff;
   logic [CONF_W-1:0]         conf_ff;
   logic [TOK_W-1:0]          prev_ff;
   logic [CS_W-1:0]           csum_ff;
   logic [CNT_W-1:0]          tcnt_ff;

   logic signed [LOGIT_W:0]   diff_full;
   logic [DIFF_W-1:0]         diff_clip;
   logic [2*EXP_W-1:0]        prod;
   logic [D_W:0]              rem_sh;
   logic                      q_bit;
   logic                      div_last;
   logic [EXP_W-1:0]          quo_next;
   logic [CONF_W-1:0]         quo_sat;
   logic [RS_W-1:0]           rowsum_next;
   logic [TOK_W-1:0]          tok;
   logic                      emit_tok;
   logic                      row_last;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (state_ff == B_READ) begin
         rdata_ff <= mem[{job_ff.bank, i_ff}];
      end
   end

   assign diff_full = (LOGIT_W+1)'(job_ff.max_value) - (LOGIT_W+1)'(rdata_ff);
   assign diff_clip = (diff_full > (LOGIT_W+1)'(DIFF_CLIP)) ? DIFF_CLIP : diff_full[DIFF_W-1:0];
   assign prod = (2*EXP_W)'(e_ff) * (2*EXP_W)'(exp_factor(bit_ff)) + (2*EXP_W)'(32768);

   assign rem_sh   = {rem_ff, dvd_ff[DV_W-1]};
   assign q_bit    = (rem_sh >= {1'b0, dvs_ff});
   assign quo_next = {quo_ff[EXP_W-2:0], q_bit};
   assign div_last = (dcnt_ff == DC_W'(DV_W - 1));
   assign quo_sat  = (quo_next >= EXP_W'(CONF_SAT)) ? CONF_SAT : quo_next[CONF_W-1:0];
   assign rowsum_next = rowsum_ff + RS_W'(e_ff);
   assign row_last = (JOB_IDX_W'(i_ff) == job_ff.last_pos);

   // widen, then keep the low 7 bits like the previous-token register
   assign tok      = TOK_W'({{TOK_W{1'b0}}, job_ff.max_index});
   assign emit_tok = (tok != '0) && (tok != prev_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               state_in = job_data.row_valid ? B_READ : B_AVG;
            end
         end
         B_READ:  state_in = B_LOAD;
         B_LOAD:  state_in = B_EXP;
         B_EXP: begin
            if (bit_ff == 4'(EXP_STEPS - 1)) begin
               state_in = B_ACC;
            end
         end
         B_ACC:   state_in = row_last ? B_DIV : B_READ;
         B_DIV: begin
            if (div_last) begin
               if (div_avg_ff) begin
                  state_in = B_SUM;
               end else if (emit_tok) begin
                  state_in = B_TOK;
               end else if (job_ff.eou) begin
                  state_in = B_AVG;
               end else begin
                  state_in = B_IDLE;
               end
            end
         end
         B_TOK: begin
            if (!out_full) begin
               state_in = job_ff.eou ? B_AVG : B_IDLE;
            end
         end
         B_AVG:   state_in = (tcnt_ff == '0) ? B_SUM : B_DIV;
         B_SUM: begin
            if (!out_full) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      job_pop  = 1'b0;
      job_done = 1'b0;
      out_push = 1'b0;
      out_data = '0;
      case (state_ff)
         B_IDLE:  job_pop = !job_empty;
         B_DIV: begin
            job_done = div_last && !div_avg_ff && !emit_tok && !job_ff.eou;
         end
         B_TOK: begin
            out_push = !out_full;
            job_done = !out_full && !job_ff.eou;
            out_data.token_id         = TOKEN_ID_W'(tok);
            out_data.token_confidence = conf_ff;
         end
         B_SUM: begin
            out_push = !out_full;
            job_done = !out_full;
            out_data.kind = 1'b1;
            out_data.last = 1'b1;
            out_data.utterance_confidence = conf_ff;
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         prev_ff  <= PREV_NONE;
         csum_ff  <= '0;
         tcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_DIV && div_last && !div_avg_ff) begin
            prev_ff <= tok;
         end
         if (state_ff == B_TOK && !out_full && tcnt_ff < STEP_CAP) begin
            csum_ff <= csum_ff + CS_W'(conf_ff);
            tcnt_ff <= tcnt_ff + CNT_W'(1);
         end
         if (state_ff == B_SUM && !out_full) begin
            prev_ff <= PREV_NONE;
            csum_ff <= '0;
            tcnt_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            job_ff    <= job_data;
            i_ff      <= '0;
            rowsum_ff <= '0;
         end
         B_LOAD: begin
            diff_ff <= diff_clip;
            e_ff    <= EXP_ONE;
            bit_ff  <= '0;
         end
         B_EXP: begin
            if (diff_ff[bit_ff]) begin
               e_ff <= prod[16 +: EXP_W];
            end
            bit_ff <= bit_ff + 4'd1;
         end
         B_ACC: begin
            rowsum_ff <= rowsum_next;
            i_ff      <= i_ff + POS_W'(1);
            // 2^32 / row sum
            rem_ff     <= '0;
            dvd_ff     <= DIV_ONE;
            dvs_ff     <= D_W'(rowsum_next);
            quo_ff     <= '0;
            dcnt_ff    <= '0;
            div_avg_ff <= 1'b0;
         end
         B_DIV: begin
            rem_ff  <= q_bit ? D_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[D_W-1:0];
            dvd_ff  <= {dvd_ff[DV_W-2:0], 1'b0};
            quo_ff  <= quo_next;
            dcnt_ff <= dcnt_ff + DC_W'(1);
            if (div_last) begin
               conf_ff <= quo_sat;
            end
         end
         B_AVG: begin
            rem_ff     <= '0;
            dvd_ff     <= DV_W'(csum_ff);
            dvs_ff     <= D_W'(tcnt_ff);
            quo_ff     <= '0;
            dcnt_ff    <= '0;
            div_avg_ff <= 1'b1;
            conf_ff    <= '0;
         end
         default: begin
            diff_ff <= diff_ff;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/core/ctc_greedy_decode_confidence_top.sv
`default_nettype none
// Flow: a row of N logits is taken one per cycle while req_full is low; after the last
//   logit the job is picked up, each entry is read and put through a bit-serial exp, the
//   shared divider forms the confidence and the token result is pushed; a summary divides too.
// Throughput: two row banks let the next row stream in while one is reduced; input
//   stalls only when both banks are held by rows still being reduced.
// Reset: synchronous, active high; clears control and utterance state, vocab count 32.
module ctc_greedy_decode_confidence_top
   import ctcgd_pkg::*;
#(
   parameter int VOCAB_MAX = 64,
   parameter int MAX_STEPS = 65536
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic [CSR_W-1:0] csr_write_data,
   input  wire logic             req_push,
   input  wire req_type          req_data,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output rsp_type               rsp_data
);

   localparam int AW = $clog2(VOCAB_MAX) + 1;

   logic                      mem_wr_en;
   logic [AW-1:0]             mem_wr_addr;
   logic signed [LOGIT_W-1:0] mem_wr_data;
   logic                      job_push, job_pop, job_empty, job_full, job_done;
   job_type                   job_in, job_out;
   logic                      out_push, out_full;
   rsp_type                   out_data;

   ctcgd_front #(
      .VOCAB_MAX(VOCAB_MAX)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_push         (req_push),
      .req_data         (req_data),
      .req_full         (req_full),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .job_push         (job_push),
      .job_data         (job_in),
      .job_done         (job_done)
   );

   ctcgd_fifo #(
      .WIDTH($bits(job_type))
   ) u_job_q (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out),
      .empty     (job_empty)
   );

   ctcgd_back #(
      .VOCAB_MAX(VOCAB_MAX),
      .MAX_STEPS(MAX_STEPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .job_empty   (job_empty || job_full && 1'b0),
      .job_data    (job_out),
      .job_pop     (job_pop),
      .job_done    (job_done),
      .out_full    (out_full),
      .out_push    (out_push),
      .out_data    (out_data)
   );

   ctcgd_fifo #(
      .WIDTH($bits(rsp_type))
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule
`default_nettype wire

>>> test/tb_ctc_greedy_decode_confidence_top.sv
`default_nettype none
module tb_ctc_greedy_decode_confidence_top;
   import ctcgd_pkg::*;

   localparam int VMAX = 64;
   localparam int STEP_CAP = 65536;
   localparam logic KIND_TOKEN = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;
   localparam int CYCLE_LIMIT = 2000000;
   // row of 64 entries through the serial exp, plus divider and summary
   localparam int DRAIN_CYCLES = 64 * 16 + 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_W-1:0] csr_write_data = '0;
   logic req_push = 1'b0;
   req_type req_data = '0;
   logic req_full;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;

   ctc_greedy_decode_confidence_top dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // decoder model state
   logic [6:0] vocab_reg;
   logic signed [15:0] row_vals [VMAX];
   int unsigned row_pos;
   logic signed [15:0] run_max;
   int unsigned run_idx;
   int unsigned prev_tok;
   longint unsigned conf_total;
   longint unsigned tok_total;

   rsp_type expected_results [$];
   int errors = 0;
   int sent = 0;
   int tokens_seen = 0;
   int summaries_seen = 0;
   int cycles = 0;
   bit hold_rsp = 1'b0;
   int hold_cycles = 0;

   int unsigned exp_steps [13] = '{65280, 65026, 64520, 63520, 61565, 57835,
      51039, 39750, 24109, 8869, 1200, 22, 0};

   function automatic int unsigned exp_of_gap(int unsigned d);
      longint unsigned e;
      e = 65536;
      if (d > 4096) d = 4096;
      for (int b = 0; b < 13; b++)
         if (d[b]) e = (e * exp_steps[b] + 32768) >> 16;
      return int'(e);
   endfunction

   function automatic void clear_utterance();
      row_pos = 0;
      run_max = 0;
      run_idx = 0;
      prev_tok = 127;
      conf_total = 0;
      tok_total = 0;
   endfunction

   function automatic void decode_logit(req_type item);
      int unsigned cnt;
      int unsigned slot;
      longint unsigned total;
      longint unsigned quot;
      int unsigned conf;
      rsp_type r;
      cnt = vocab_reg;
      if (cnt == 0) cnt = 1;
      if (cnt > VMAX) cnt = VMAX;
      slot = (row_pos < VMAX) ? row_pos : (row_pos & (VMAX - 1));
      row_vals[slot] = item.logit;
      if (row_pos == 0 || item.logit > run_max) begin
         run_max = item.logit;
         run_idx = row_pos;
      end
      if (row_pos + 1 >= cnt) begin
         total = 0;
         for (int i = 0; i <= slot; i++)
            total += exp_of_gap(int'(run_max) - int'(row_vals[i]));
         quot = 64'h1_0000_0000 / total;
         conf = (quot < 65535) ? int'(quot) : 65535;
         if ((run_idx & 127) != 0 && (run_idx & 127) != prev_tok) begin
            r = '0;
            r.kind = KIND_TOKEN;
            r.token_id = run_idx[5:0];
            r.token_confidence = conf[15:0];
            expected_results.push_back(r);
            if (tok_total < STEP_CAP) begin
               conf_total += conf;
               tok_total++;
            end
         end
         prev_tok = run_idx & 127;
         row_pos = 0;
      end else begin
         row_pos++;
      end
      if (item.end_of_utterance) begin
         r = '0;
         r.kind = KIND_SUMMARY;
         quot = (tok_total != 0) ? conf_total / tok_total : 0;
         r.utterance_confidence = (quot > 65535) ? 16'hffff : quot[15:0];
         r.last = 1'b1;
         expected_results.push_back(r);
         clear_utterance();
      end
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (time %0t)", what, got, want, $time);
   endtask

   // req_push stays high across back-to-back items; it drops before a gap
   task automatic push_logit(logic signed [15:0] v, logic eou, int gap = -1);
      req_type item;
      if (gap < 0) gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.logit = v;
      item.end_of_utterance = eou;
      req_data <= item;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      decode_logit(item);
      sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_vocab(logic [6:0] v);
      wait_drained();
      csr_write_data <= v;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      vocab_reg = v;
   endtask

   task automatic send_row(int n, int win, logic eou, bit hot);
      logic signed [15:0] v;
      for (int i = 0; i < n; i++) begin
         if (hot) v = (i == win) ? 16'sd2000 : 16'(int'($urandom_range(0, 4000)) - 2000);
         else v = 16'($urandom);
         push_logit(v, eou && (i == n - 1));
      end
   endtask

   // long receiver stall
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            hold_rsp <= 1'b1;
         end else begin
            hold_rsp <= 1'b0;
         end
      end
   end

   // result checker and random receiver stalls
   initial begin
      rsp_type want;
      int wait_n;
      wait_n = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result transfer", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.kind != want.kind)
                  report_mismatch("kind", rsp_data.kind, want.kind);
               if (rsp_data.token_id != want.token_id)
                  report_mismatch("token_id", rsp_data.token_id, want.token_id);
               if (rsp_data.token_confidence != want.token_confidence)
                  report_mismatch("token_confidence", rsp_data.token_confidence,
                     want.token_confidence);
               if (rsp_data.utterance_confidence != want.utterance_confidence)
                  report_mismatch("utterance_confidence", rsp_data.utterance_confidence,
                     want.utterance_confidence);
               if (rsp_data.last != want.last)
                  report_mismatch("last", rsp_data.last, want.last);
               if (want.kind == KIND_TOKEN) tokens_seen++;
               else summaries_seen++;
            end
            wait_n = $urandom_range(0, 5);
         end
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
         end else if (wait_n > 0) begin
            wait_n--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic test_extremes();
      write_vocab(7'd4);
      push_logit(16'sh7fff, 1'b0); push_logit(-16'sd32768, 1'b0);
      push_logit(16'sd0, 1'b0); push_logit(16'sh7fff, 1'b0);
      // tie on index 1 and 3, first wins
      push_logit(16'sd0, 1'b0); push_logit(16'sd5, 1'b0);
      push_logit(16'sd1, 1'b0); push_logit(16'sd5, 1'b1);
      // blank winner, repeated token, early end
      send_row(4, 0, 1'b0, 1'b1);
      send_row(4, 2, 1'b0, 1'b1);
      send_row(4, 2, 1'b0, 1'b1);
      push_logit(16'sd3, 1'b0); push_logit(16'sd9, 1'b1);
      push_logit(16'sd7, 1'b1); // summary with no tokens, single logit
   endtask

   task automatic test_vocab_limits();
      write_vocab(7'd0);
      push_logit(16'sd100, 1'b0); push_logit(-16'sd100, 1'b1);
      write_vocab(7'd1);
      push_logit(16'sd1, 1'b1);
      write_vocab(7'd127);
      send_row(64, 63, 1'b1, 1'b1);
      write_vocab(7'd64);
      send_row(64, 17, 1'b1, 1'b0);
   endtask

   task automatic test_random_utterances();
      int n, rows, win;
      for (int u = 0; u < 22; u++) begin
         // one utterance at vocab 32, the rest at small sizes
         if (u % 8 == 0 || u == 17) begin
            n = (u == 16) ? 32 : $urandom_range(2, 8);
            write_vocab(n[6:0]);
         end
         rows = $urandom_range(1, 4);
         for (int r = 0; r < rows; r++) begin
            win = $urandom_range(0, n - 1);
            if ($urandom_range(0, 9) == 0) begin
               // broken row, possibly ending early
               send_row($urandom_range(1, n), win, 1'b1, 1'b1);
               break;
            end
            send_row(n, win, r == rows - 1, $urandom_range(0, 3) != 0);
         end
      end
   endtask

   task automatic test_backpressure();
      write_vocab(7'd3);
      hold_cycles = 400;
      for (int r = 0; r < 20; r++) send_row(3, r % 3, r == 19, 1'b1);
      wait_drained();
      for (int r = 0; r < 6; r++) send_row(3, 1 + (r % 2), r == 5, 1'b1);
   endtask

   initial begin
      vocab_reg = VOCAB_RESET;
      clear_utterance();
      for (int i = 0; i < VMAX; i++) row_vals[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_vocab_limits();
      test_random_utterances();
      test_backpressure();
      wait_drained();
      $display("sent %0d logits; checked %0d tokens and %0d summaries", sent,
         tokens_seen, summaries_seen);
      $display("vocab sizes 0,1,2..8,32,64,127; stalls, ties, early ends covered");
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
